// ===== hdl/clip_pkg.sv =====
package clip_pkg;

  // Grid size along each axis.
  localparam int CELLS_X = 16;
  localparam int CELLS_Y = 16;
  localparam int CELLS_Z = 16;
  localparam int DEPTH   = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int AW      = $clog2(DEPTH);
  localparam int XW      = $clog2(CELLS_X);
  localparam int YW      = $clog2(CELLS_Y);
  localparam int ZW      = $clog2(CELLS_Z);

  // Word of one grid cell in storage: label above distance.
  localparam int CELL_W  = 40;

  localparam int ONE_Q   = 65536;
  localparam int HALF_Q  = ONE_Q / 2;

  // Opcodes of an input item.
  localparam logic OPC_WRITE = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_INV_X     = 3'd3;
  localparam logic [2:0] REG_INV_Y     = 3'd4;
  localparam logic [2:0] REG_INV_Z     = 3'd5;
  localparam logic [2:0] REG_CENTERED  = 3'd6;
  localparam logic [2:0] REG_PLANAR    = 3'd7;

  // Axis codes used by the mapping unit.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_FIN,
    S_RD_E,
    S_RD_O,
    S_CAP_O,
    S_BL_MUL,
    S_BL_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    LVL_X,
    LVL_Y,
    LVL_Z
  } level_t;

  typedef struct packed {
    logic       wr_cell;
    logic       start;
    logic       map_mul;
    logic       map_fin;
    logic [1:0] axis;
    logic       rd_en;
    logic [2:0] corner;
    logic       cap;
    logic       bl_mul;
    logic       bl_fin;
    level_t     level;
    logic       save_px;
    logic       save_py;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/clip_ram.sv =====
module clip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/clip_ctrl.sv =====
module clip_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           opcode,
  input  logic           planar,
  input  clip_pkg::sts_t sts,
  output logic           in_stall,
  output clip_pkg::cmd_t cmd
);

  clip_pkg::state_t state, state_next;
  clip_pkg::level_t level, level_next;
  logic [1:0] axis, axis_next;
  logic [1:0] pair, pair_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= clip_pkg::S_IDLE;
      level <= clip_pkg::LVL_X;
      axis  <= clip_pkg::AXIS_X;
      pair  <= 2'd0;
    end else begin
      state <= state_next;
      level <= level_next;
      axis  <= axis_next;
      pair  <= pair_next;
    end
  end

  assign in_stall = (state != clip_pkg::S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next  = state;
    level_next  = level;
    axis_next   = axis;
    pair_next   = pair;
    cmd         = '0;
    cmd.axis    = axis;
    cmd.level   = level;
    cmd.corner  = {pair, 1'b0};
    case (state)
      clip_pkg::S_IDLE: begin
        cmd.wr_cell = accept && (opcode == clip_pkg::OPC_WRITE);
        cmd.start   = accept && (opcode == clip_pkg::OPC_QUERY);
        if (cmd.start) begin
          state_next = clip_pkg::S_MAP_MUL;
          axis_next  = clip_pkg::AXIS_X;
        end
      end
      clip_pkg::S_MAP_MUL: begin
        cmd.map_mul = 1'b1;
        state_next  = clip_pkg::S_MAP_FIN;
      end
      clip_pkg::S_MAP_FIN: begin
        cmd.map_fin = 1'b1;
        if ((planar && axis == clip_pkg::AXIS_Y) || axis == clip_pkg::AXIS_Z) begin
          state_next = clip_pkg::S_RD_E;
          pair_next  = 2'd0;
        end else begin
          state_next = clip_pkg::S_MAP_MUL;
          axis_next  = axis + 2'd1;
        end
      end
      clip_pkg::S_RD_E: begin
        cmd.rd_en  = 1'b1;
        cmd.corner = {pair, 1'b0};
        state_next = clip_pkg::S_RD_O;
      end
      clip_pkg::S_RD_O: begin
        cmd.rd_en  = 1'b1;
        cmd.corner = {pair, 1'b1};
        cmd.cap    = 1'b1;
        state_next = clip_pkg::S_CAP_O;
      end
      clip_pkg::S_CAP_O: begin
        cmd.cap    = 1'b1;
        state_next = clip_pkg::S_BL_MUL;
        level_next = clip_pkg::LVL_X;
      end
      clip_pkg::S_BL_MUL: begin
        cmd.bl_mul = 1'b1;
        state_next = clip_pkg::S_BL_FIN;
      end
      clip_pkg::S_BL_FIN: begin
        cmd.bl_fin  = 1'b1;
        cmd.save_px = (level == clip_pkg::LVL_X) && !pair[0];
        cmd.save_py = (level == clip_pkg::LVL_Y) && (pair == 2'd1);
        case (level)
          clip_pkg::LVL_X: begin
            if (!pair[0]) begin
              state_next = clip_pkg::S_RD_E;
              pair_next  = pair + 2'd1;
            end else begin
              state_next = clip_pkg::S_BL_MUL;
              level_next = clip_pkg::LVL_Y;
            end
          end
          clip_pkg::LVL_Y: begin
            if (pair == 2'd3) begin
              state_next = clip_pkg::S_BL_MUL;
              level_next = clip_pkg::LVL_Z;
            end else if (planar) begin
              state_next = clip_pkg::S_OUT;
            end else begin
              state_next = clip_pkg::S_RD_E;
              pair_next  = 2'd2;
            end
          end
          default: begin
            state_next = clip_pkg::S_OUT;
          end
        endcase
      end
      clip_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = clip_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = clip_pkg::S_IDLE;
      end
    endcase
  end

  a_query_starts_map: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == clip_pkg::OPC_QUERY) |=>
      (state == clip_pkg::S_MAP_MUL && axis == clip_pkg::AXIS_X))
    else $error("query did not start the mapping sequence");

  a_planar_no_z: assert property (@(posedge clk) disable iff (rst)
    (planar && state == clip_pkg::S_BL_MUL) |-> (level != clip_pkg::LVL_Z))
    else $error("z blend in planar mode");

  a_px_even_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.save_px |-> (!pair[0] && state == clip_pkg::S_BL_FIN))
    else $error("x partial saved on an odd pair");

  a_out_done: assert property (@(posedge clk) disable iff (rst)
    (state == clip_pkg::S_OUT && sts.out_free) |=> (state == clip_pkg::S_IDLE))
    else $error("result load did not end the query");

endmodule

// ===== hdl/clip_dp.sv =====
module clip_dp (
  input  logic                clk,
  input  logic                rst,
  input  clip_pkg::cmd_t      cmd,
  output clip_pkg::sts_t      sts,
  input  logic signed [31:0]  origin_x,
  input  logic signed [31:0]  origin_y,
  input  logic signed [31:0]  origin_z,
  input  logic        [31:0]  inv_spacing_x,
  input  logic        [31:0]  inv_spacing_y,
  input  logic        [31:0]  inv_spacing_z,
  input  logic                cell_centered,
  input  logic        [3:0]   cell_x,
  input  logic        [3:0]   cell_y,
  input  logic        [3:0]   cell_z,
  input  logic signed [31:0]  cell_distance,
  input  logic signed [7:0]   cell_label,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic                out_stall,
  output logic                out_valid,
  output logic signed [31:0]  interp_distance,
  output logic signed [7:0]   interp_label
);

  localparam logic signed [34:0] LIM_X = 35'(clip_pkg::CELLS_X - 2);
  localparam logic signed [34:0] LIM_Y = 35'(clip_pkg::CELLS_Y - 2);
  localparam logic signed [34:0] LIM_Z = 35'(clip_pkg::CELLS_Z - 2);
  localparam logic signed [50:0] HALF  = 51'(clip_pkg::HALF_Q);
  localparam logic signed [50:0] ONE51 = 51'(clip_pkg::ONE_Q);
  localparam logic signed [34:0] SMAX  = 35'sh0_7FFF_FFFF;
  localparam logic signed [34:0] SMIN  = -35'sh0_8000_0000;

  // Query point held for the whole query.
  logic signed [31:0] qpos_x, qpos_y, qpos_z;

  // Mapping unit.
  logic signed [31:0] sel_pos, sel_org;
  logic        [31:0] sel_inv;
  logic signed [34:0] sel_lim;
  logic signed [32:0] diff;
  logic signed [49:0] prod_hi, prod_lo;
  logic signed [50:0] grid;
  logic signed [34:0] gidx, idx_cl;
  logic signed [50:0] gfrac;
  logic        [16:0] frac_cl;

  logic [clip_pkg::XW-1:0] ix;
  logic [clip_pkg::YW-1:0] iy;
  logic [clip_pkg::ZW-1:0] iz;
  logic [16:0]             fx, fy, fz;

  // Cell store.
  logic                          wr_ok;
  logic [clip_pkg::AW-1:0]       wr_addr, rd_addr;
  logic [clip_pkg::CELL_W-1:0]   rd_data;
  logic [clip_pkg::XW-1:0]       cx;
  logic [clip_pkg::YW-1:0]       cy;
  logic [clip_pkg::ZW-1:0]       cz;

  // Corner pair and partial results.
  logic signed [31:0] sh0_d, sh1_d, px_d, py_d, res_d;
  logic signed [7:0]  sh0_c, sh1_c, px_c, py_c, res_c;

  // Blend unit.
  logic signed [31:0] op0_d, op1_d;
  logic signed [7:0]  op0_c, op1_c;
  logic        [16:0] op_a;
  logic signed [17:0] w0, w1;
  logic signed [49:0] bm0, bm1;
  logic signed [7:0]  bc0, bc1;
  logic signed [50:0] bsum, bdif, bneg;
  logic signed [34:0] bval;
  logic signed [31:0] bsat;
  logic signed [7:0]  blab;

  always_comb begin
    case (cmd.axis)
      clip_pkg::AXIS_X: begin
        sel_pos = qpos_x; sel_org = origin_x; sel_inv = inv_spacing_x; sel_lim = LIM_X;
      end
      clip_pkg::AXIS_Y: begin
        sel_pos = qpos_y; sel_org = origin_y; sel_inv = inv_spacing_y; sel_lim = LIM_Y;
      end
      default: begin
        sel_pos = qpos_z; sel_org = origin_z; sel_inv = inv_spacing_z; sel_lim = LIM_Z;
      end
    endcase
    diff = {sel_pos[31], sel_pos} - {sel_org[31], sel_org};
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qpos_x <= pos_x;
      qpos_y <= pos_y;
      qpos_z <= pos_z;
    end
    if (cmd.map_mul) begin
      prod_hi <= diff * $signed({1'b0, sel_inv[31:16]});
      prod_lo <= diff * $signed({1'b0, sel_inv[15:0]});
    end
  end

  always_comb begin
    grid = {prod_hi[49], prod_hi} + {{17{prod_lo[49]}}, prod_lo[49:16]}
         - (cell_centered ? HALF : 51'sd0);
    gidx = grid[50:16];
    if (gidx < 35'sd0) begin
      idx_cl = 35'sd0;
    end else if (gidx > sel_lim) begin
      idx_cl = sel_lim;
    end else begin
      idx_cl = gidx;
    end
    gfrac = grid - {idx_cl, 16'b0};
    if (gfrac < 51'sd0) begin
      frac_cl = 17'd0;
    end else if (gfrac > ONE51) begin
      frac_cl = 17'(clip_pkg::ONE_Q);
    end else begin
      frac_cl = gfrac[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      iz <= '0;
      fz <= 17'd0;
    end else if (cmd.map_fin) begin
      case (cmd.axis)
        clip_pkg::AXIS_X: begin
          ix <= idx_cl[clip_pkg::XW-1:0];
          fx <= frac_cl;
        end
        clip_pkg::AXIS_Y: begin
          iy <= idx_cl[clip_pkg::YW-1:0];
          fy <= frac_cl;
        end
        default: begin
          iz <= idx_cl[clip_pkg::ZW-1:0];
          fz <= frac_cl;
        end
      endcase
    end
  end

  // Cell addressing: x runs fastest, then y, then z.
  always_comb begin
    wr_ok = (int'(cell_x) < clip_pkg::CELLS_X) && (int'(cell_y) < clip_pkg::CELLS_Y)
         && (int'(cell_z) < clip_pkg::CELLS_Z);
    wr_addr = clip_pkg::AW'(cell_x) + clip_pkg::AW'(clip_pkg::CELLS_X)
            * (clip_pkg::AW'(cell_y) + clip_pkg::AW'(clip_pkg::CELLS_Y)
            * clip_pkg::AW'(cell_z));
    cx = ix + clip_pkg::XW'(cmd.corner[0]);
    cy = iy + clip_pkg::YW'(cmd.corner[1]);
    cz = iz + clip_pkg::ZW'(cmd.corner[2]);
    rd_addr = clip_pkg::AW'(cx) + clip_pkg::AW'(clip_pkg::CELLS_X)
            * (clip_pkg::AW'(cy) + clip_pkg::AW'(clip_pkg::CELLS_Y) * clip_pkg::AW'(cz));
  end

  clip_ram #(
    .WIDTH (clip_pkg::CELL_W),
    .DEPTH (clip_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_cell && wr_ok),
    .wr_addr (wr_addr),
    .wr_data ({cell_label, cell_distance}),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      sh0_d <= sh1_d;
      sh0_c <= sh1_c;
      sh1_d <= rd_data[31:0];
      sh1_c <= rd_data[39:32];
    end
  end

  always_comb begin
    case (cmd.level)
      clip_pkg::LVL_Y: begin
        op0_d = px_d; op0_c = px_c; op1_d = res_d; op1_c = res_c; op_a = fy;
      end
      clip_pkg::LVL_Z: begin
        op0_d = py_d; op0_c = py_c; op1_d = res_d; op1_c = res_c; op_a = fz;
      end
      default: begin
        op0_d = sh0_d; op0_c = sh0_c; op1_d = sh1_d; op1_c = sh1_c; op_a = fx;
      end
    endcase
    w1 = $signed({1'b0, op_a});
    w0 = 18'(clip_pkg::ONE_Q) - w1;
  end

  always_ff @(posedge clk) begin
    if (cmd.bl_mul) begin
      bm0 <= op0_d * w0;
      bm1 <= op1_d * w1;
      bc0 <= op0_c;
      bc1 <= op1_c;
    end
  end

  // Same colours blend linearly; different colours pick by the sign of the
  // signed blend and keep its magnitude.
  always_comb begin
    bsum = {bm0[49], bm0} + {bm1[49], bm1};
    bdif = {bm0[49], bm0} - {bm1[49], bm1};
    bneg = -bdif;
    if (bc0 == bc1) begin
      bval = bsum[50:16];
      blab = bc0;
    end else if (bdif >= 51'sd0) begin
      bval = bdif[50:16];
      blab = bc0;
    end else begin
      bval = bneg[50:16];
      blab = bc1;
    end
    if (bval > SMAX) begin
      bsat = 32'sh7FFF_FFFF;
    end else if (bval < SMIN) begin
      bsat = 32'sh8000_0000;
    end else begin
      bsat = bval[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bl_fin) begin
      res_d <= bsat;
      res_c <= blab;
      if (cmd.save_px) begin
        px_d <= bsat;
        px_c <= blab;
      end
      if (cmd.save_py) begin
        py_d <= bsat;
        py_c <= blab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      interp_distance <= res_d;
      interp_label    <= res_c;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

endmodule

// ===== hdl/color_levelset_interpolator.sv =====
// Channel  | Direction | Handshake           | Payload
// ---------+-----------+---------------------+---------------------------------------------
// input    | in        | in_valid / in_stall | opcode, cell_x/y/z, cell_distance,
//          |           |                     | cell_label, pos_x/y/z
// result   | out       | out_valid/out_stall | interp_distance, interp_label
// config   | in        | APB psel/penable    | paddr, pwdata, prdata, pready
//
// The transfer of a cell write itself writes the cell store. A query
// stalls the input from its transfer until its result is loaded, so no
// new item is taken meanwhile; the single read port of the cell store and
// the shared mapping and blend multipliers make its steps run in turn.
// Reset is synchronous; it sets the control state, the configuration
// registers and the result valid flag to their defaults. The cell store
// is not cleared and holds nothing defined until written. A stalled
// result waits in the output register; the input stalls only during a query.
module color_levelset_interpolator (
  input  logic               clk,
  input  logic               rst,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic        [3:0]  cell_x,
  input  logic        [3:0]  cell_y,
  input  logic        [3:0]  cell_z,
  input  logic signed [31:0] cell_distance,
  input  logic signed [7:0]  cell_label,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] interp_distance,
  output logic signed [7:0]  interp_label,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [4:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  // Configuration registers, each at a word address in list order.
  logic signed [31:0] origin_x, origin_y, origin_z;
  logic        [31:0] inv_spacing_x, inv_spacing_y, inv_spacing_z;
  logic               cell_centered, planar_mode;
  logic               cfg_wr;
  logic        [2:0]  cfg_idx;

  clip_pkg::cmd_t cmd;
  clip_pkg::sts_t sts;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      inv_spacing_x <= 32'(clip_pkg::ONE_Q);
      inv_spacing_y <= 32'(clip_pkg::ONE_Q);
      inv_spacing_z <= 32'(clip_pkg::ONE_Q);
      cell_centered <= 1'b0;
      planar_mode   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        clip_pkg::REG_ORIGIN_X: origin_x      <= pwdata;
        clip_pkg::REG_ORIGIN_Y: origin_y      <= pwdata;
        clip_pkg::REG_ORIGIN_Z: origin_z      <= pwdata;
        clip_pkg::REG_INV_X:    inv_spacing_x <= pwdata;
        clip_pkg::REG_INV_Y:    inv_spacing_y <= pwdata;
        clip_pkg::REG_INV_Z:    inv_spacing_z <= pwdata;
        clip_pkg::REG_CENTERED: cell_centered <= pwdata[0];
        clip_pkg::REG_PLANAR:   planar_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      clip_pkg::REG_ORIGIN_X: prdata = origin_x;
      clip_pkg::REG_ORIGIN_Y: prdata = origin_y;
      clip_pkg::REG_ORIGIN_Z: prdata = origin_z;
      clip_pkg::REG_INV_X:    prdata = inv_spacing_x;
      clip_pkg::REG_INV_Y:    prdata = inv_spacing_y;
      clip_pkg::REG_INV_Z:    prdata = inv_spacing_z;
      clip_pkg::REG_CENTERED: prdata = {31'b0, cell_centered};
      default:                prdata = {31'b0, planar_mode};
    endcase
  end

  // The controller sequences mapping, corner reads and pairwise blends.
  clip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .planar   (planar_mode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // The datapath holds the cell store, the arithmetic and the result register.
  clip_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .origin_x        (origin_x),
    .origin_y        (origin_y),
    .origin_z        (origin_z),
    .inv_spacing_x   (inv_spacing_x),
    .inv_spacing_y   (inv_spacing_y),
    .inv_spacing_z   (inv_spacing_z),
    .cell_centered   (cell_centered),
    .cell_x          (cell_x),
    .cell_y          (cell_y),
    .cell_z          (cell_z),
    .cell_distance   (cell_distance),
    .cell_label      (cell_label),
    .pos_x           (pos_x),
    .pos_y           (pos_y),
    .pos_z           (pos_z),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .interp_distance (interp_distance),
    .interp_label    (interp_label)
  );

endmodule

// ===== test/tb.sv =====
// Scoreboard for the interpolated distance and label results.
class interp_scoreboard;
  logic signed [31:0] dist_q[$];
  logic signed [7:0]  label_q[$];
  int                 mismatches;

  function void note_query(logic signed [31:0] d, logic signed [7:0] l);
    dist_q.push_back(d);
    label_q.push_back(l);
  endfunction

  function void check_result(logic signed [31:0] d, logic signed [7:0] l);
    logic signed [31:0] ed;
    logic signed [7:0]  el;
    if (dist_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %0d label %0d", d, l);
      return;
    end
    ed = dist_q.pop_front();
    el = label_q.pop_front();
    if (ed !== d || el !== l) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected %0d/%0d, got %0d/%0d", ed, el, d, l);
    end
  endfunction

  function int pending();
    return dist_q.size();
  endfunction
endclass

module tb;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = clip_pkg::OPC_WRITE;
  logic        [3:0]  cell_x = '0, cell_y = '0, cell_z = '0;
  logic signed [31:0] cell_distance = '0;
  logic signed [7:0]  cell_label = '0;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] interp_distance;
  logic signed [7:0]  interp_label;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic        [4:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;

  color_levelset_interpolator dut (.*);

  always #2 clk = ~clk;

  // The testbench's own copy of the grid and the registers.
  logic signed [31:0] grid_dist[clip_pkg::DEPTH];
  logic signed [7:0]  grid_label[clip_pkg::DEPTH];
  bit                 written[clip_pkg::DEPTH];
  logic signed [31:0] org[3];
  logic        [31:0] inv[3];
  logic               centred, planar;

  interp_scoreboard sb = new();
  int  idle_pct = 23;
  bit  rx_hold = 1'b0;
  int  quiet_cycles = 0;
  bit  timed_out = 1'b0;

  function automatic longint floor_div(longint v);
    if (v >= 0) return v / clip_pkg::ONE_Q;
    return -((-v + (clip_pkg::ONE_Q - 1)) / clip_pkg::ONE_Q);
  endfunction

  // Maps one coordinate to a clamped base index and fraction.
  function automatic void map_axis(longint p, longint o, logic [31:0] s,
                                   output longint idx, output longint fr);
    longint d, g;
    d = p - o;
    g = d * longint'(s[31:16]) + floor_div(d * longint'(s[15:0]));
    if (centred) g -= clip_pkg::HALF_Q;
    idx = floor_div(g);
    if (idx < 0) idx = 0;
    if (idx > 14) idx = 14;
    fr = g - idx * clip_pkg::ONE_Q;
    if (fr < 0) fr = 0;
    if (fr > clip_pkg::ONE_Q) fr = clip_pkg::ONE_Q;
  endfunction

  function automatic void predict_query(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz,
      output logic signed [31:0] rd, output logic signed [7:0] rl);
    longint ix[3], fr[3], dv[8], r, v;
    logic signed [7:0] cv[8];
    int n, a;
    map_axis(px, org[0], inv[0], ix[0], fr[0]);
    map_axis(py, org[1], inv[1], ix[1], fr[1]);
    if (planar) begin
      ix[2] = 0; fr[2] = 0;
    end else begin
      map_axis(pz, org[2], inv[2], ix[2], fr[2]);
    end
    n = planar ? 4 : 8;
    for (int k = 0; k < n; k++) begin
      a = (ix[0] + (k & 1)) + 16 * ((ix[1] + ((k >> 1) & 1)) + 16 * (ix[2] + (k >> 2)));
      dv[k] = grid_dist[a];
      cv[k] = grid_label[a];
    end
    for (int lvl = 0; n > 1; lvl++) begin
      for (int i = 0; i < n / 2; i++) begin
        if (cv[2*i] == cv[2*i+1]) begin
          v = floor_div(dv[2*i] * (clip_pkg::ONE_Q - fr[lvl]) + dv[2*i+1] * fr[lvl]);
          cv[i] = cv[2*i];
        end else begin
          r = dv[2*i] * (clip_pkg::ONE_Q - fr[lvl]) - dv[2*i+1] * fr[lvl];
          if (r >= 0) begin
            v = r / clip_pkg::ONE_Q; cv[i] = cv[2*i];
          end else begin
            v = (-r) / clip_pkg::ONE_Q; cv[i] = cv[2*i+1];
          end
        end
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        dv[i] = v;
      end
      n /= 2;
    end
    rd = dv[0][31:0];
    rl = cv[0];
  endfunction

  // Writes one register through a setup and an access phase, then leaves
  // the port idle.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      clip_pkg::REG_ORIGIN_X: org[0] = val;
      clip_pkg::REG_ORIGIN_Y: org[1] = val;
      clip_pkg::REG_ORIGIN_Z: org[2] = val;
      clip_pkg::REG_INV_X:    inv[0] = val;
      clip_pkg::REG_INV_Y:    inv[1] = val;
      clip_pkg::REG_INV_Z:    inv[2] = val;
      clip_pkg::REG_CENTERED: centred = val[0];
      default:                planar = val[0];
    endcase
    @(posedge clk);
  endtask

  // Offers one item and waits for its transfer; the prediction is made on
  // acceptance. Valid stays high afterwards so that the next item can follow
  // at once; drain() drops it.
  task automatic send_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z,
      logic signed [31:0] d, logic signed [7:0] l,
      logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
    logic signed [31:0] ed;
    logic signed [7:0]  el;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; opcode <= op;
    cell_x <= x; cell_y <= y; cell_z <= z;
    cell_distance <= d; cell_label <= l;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == clip_pkg::OPC_WRITE) begin
      grid_dist[{z, y, x}] = d;
      grid_label[{z, y, x}] = l;
      written[{z, y, x}] = 1'b1;
    end else begin
      predict_query(px, py, pz, ed, el);
      sb.note_query(ed, el);
    end
  endtask

  task automatic send_write(logic [3:0] x, logic [3:0] y, logic [3:0] z,
                            logic signed [31:0] d, logic signed [7:0] l);
    send_item(clip_pkg::OPC_WRITE, x, y, z, d, l, $urandom, $urandom, $urandom);
  endtask

  task automatic send_query(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz);
    send_item(clip_pkg::OPC_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
              px, py, pz);
  endtask

  // Writes every corner of the query that has never been written, then
  // sends the query; every item sent is counted.
  task automatic send_covered_query(logic signed [31:0] px, logic signed [31:0] py,
                                    logic signed [31:0] pz, inout int cnt);
    longint ix[3], fr[3];
    int a;
    map_axis(px, org[0], inv[0], ix[0], fr[0]);
    map_axis(py, org[1], inv[1], ix[1], fr[1]);
    if (planar) begin
      ix[2] = 0;
    end else begin
      map_axis(pz, org[2], inv[2], ix[2], fr[2]);
    end
    for (int k = 0; k < (planar ? 4 : 8); k++) begin
      a = int'((ix[0] + (k & 1)) + 16 * ((ix[1] + ((k >> 1) & 1))
          + 16 * (ix[2] + (k >> 2))));
      if (!written[a]) begin
        send_write(a[3:0], a[7:4], a[11:8], $urandom, $urandom_range(2));
        cnt++;
      end
    end
    send_query(px, py, pz);
    cnt++;
  endtask

  // Points mostly inside the grid, with a share that lands far outside.
  function automatic logic signed [31:0] rand_pos();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(32'h0011_0000) - 32'h0000_8000;
  endfunction

  // Waits until every expected result has come, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Result side: random stalls, plus the long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) sb.check_result(interp_distance, interp_label);
      out_stall <= rx_hold || ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog: counts cycles with no transfer on the input or result channel and psel low.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    for (int i = 0; i < clip_pkg::DEPTH; i++) begin
      grid_dist[i] = 0;
      grid_label[i] = 0;
    end
    org = '{0, 0, 0};
    inv = '{clip_pkg::ONE_Q, clip_pkg::ONE_Q, clip_pkg::ONE_Q};
    centred = 1'b0;
    planar = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every corner that a query reads is written before that query, so no
    // undefined cell is read. Labels come from a small set so that both
    // blend kinds occur.
    n = 0;
    idle_pct = 23;

    // Directed: extremes of distance and label, writes outside the grid
    // (all indexes are in range here, so the top corner stands in),
    // points far outside on both sides.
    send_write(4'd0, 4'd0, 4'd0, 32'sh7fff_ffff, 8'sh7f);
    send_write(4'd1, 4'd0, 4'd0, 32'sh8000_0000, -8'sd128);
    send_write(4'd15, 4'd15, 4'd15, 32'sh8000_0000, 8'sh7f);
    send_covered_query(32'sh0000_8000, 32'sh0, 32'sh0, n);
    send_covered_query(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, n);
    send_covered_query(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, n);
    send_covered_query(32'sh000f_0000, 32'sh000f_0000, 32'sh000f_0000, n);
    send_covered_query(32'sh0, 32'sh0, 32'sh0, n);
    drain();

    // Settings in turn: extremes of every register among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(clip_pkg::REG_CENTERED, 32'd1); write_reg(clip_pkg::REG_PLANAR, 32'd0);
        end
        1: begin
          write_reg(clip_pkg::REG_PLANAR, 32'd1); write_reg(clip_pkg::REG_CENTERED, 32'd0);
        end
        2: begin
          write_reg(clip_pkg::REG_ORIGIN_X, 32'h8000_0000);
          write_reg(clip_pkg::REG_ORIGIN_Y, 32'h7fff_ffff);
          write_reg(clip_pkg::REG_ORIGIN_Z, 32'hffff_0000);
          write_reg(clip_pkg::REG_INV_X, 32'hffff_ffff);
          write_reg(clip_pkg::REG_INV_Y, 32'd0);
          write_reg(clip_pkg::REG_INV_Z, 32'h0000_8000);
          write_reg(clip_pkg::REG_PLANAR, 32'd0);
        end
        3: begin
          write_reg(clip_pkg::REG_ORIGIN_X, $urandom_range(32'h0002_0000) - 32'h0001_0000);
          write_reg(clip_pkg::REG_ORIGIN_Y, 32'h0);
          write_reg(clip_pkg::REG_ORIGIN_Z, 32'h0001_0000);
          write_reg(clip_pkg::REG_INV_X, 32'h0002_0000);
          write_reg(clip_pkg::REG_INV_Y, 32'h0000_c000);
          write_reg(clip_pkg::REG_INV_Z, $urandom_range(32'h0003_0000));
          write_reg(clip_pkg::REG_CENTERED, 32'd1);
        end
        4: begin
          write_reg(clip_pkg::REG_PLANAR, 32'd1);
          write_reg(clip_pkg::REG_INV_X, 32'h0001_0000);
          write_reg(clip_pkg::REG_INV_Y, 32'h0001_0000);
        end
        default: begin
          write_reg(clip_pkg::REG_PLANAR, 32'd0); write_reg(clip_pkg::REG_CENTERED, 32'd0);
          write_reg(clip_pkg::REG_ORIGIN_X, 32'h0); write_reg(clip_pkg::REG_ORIGIN_Z, 32'h0);
          write_reg(clip_pkg::REG_INV_Z, 32'h0001_0000);
        end
      endcase
      // The first phase runs without idling on the input side or random result
      // stalls, and the third one holds the result side off so the block backs up.
      idle_pct = (phase == 0) ? 0 : 23;
      if (phase == 2) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(posedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      n = 0;
      while (n < 170) begin
        if ($urandom_range(9) < 3) begin
          send_write($urandom, $urandom, $urandom, $urandom, $urandom_range(2));
          n++;
        end else begin
          send_covered_query(rand_pos(), rand_pos(), rand_pos(), n);
        end
      end
      // The sender pauses here until every result has come.
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
